// ===== rtl/nlaw_pkg.sv =====
// ----------------------------------------------------------------------------
// nlaw_pkg
// Types and constants shared by the netlink attribute walker.
// ----------------------------------------------------------------------------
package nlaw_pkg;

	// end status codes
	localparam logic [1:0] END_CLEAN    = 2'd0;
	localparam logic [1:0] END_SHORT    = 2'd1;
	localparam logic [1:0] END_LEN_LOW  = 2'd2;
	localparam logic [1:0] END_LEN_OVER = 2'd3;

	localparam logic [13:0] MAX_TYPE_RESET = 14'h3FFF;
	localparam logic [15:0] HDR_BYTES      = 16'd4;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_HDR   = 4'b0010,
		PH_SKIP  = 4'b0100,
		PH_DRAIN = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [15:0] stream_len;
	} nlaw_beat_t;

	typedef struct packed {
		logic        is_attr;
		logic [13:0] attr_type;
		logic [15:0] attr_offset;
		logic [15:0] attr_len;
		logic        stream_end;
		logic [1:0]  end_status;
	} nlaw_result_t;

endpackage

// ===== rtl/nlaw_if.sv =====
// ----------------------------------------------------------------------------
// nlaw_if
// Valid/ready channels of the walker: byte stream in, attribute reports out.
// ----------------------------------------------------------------------------
interface nlaw_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic [15:0] stream_len;

	modport source (output valid, data_byte, first_byte, stream_len, input ready);
	modport sink   (input valid, data_byte, first_byte, stream_len, output ready);
endinterface

interface nlaw_out_if;
	logic        valid;
	logic        ready;
	logic        is_attr;
	logic [13:0] attr_type;
	logic [15:0] attr_offset;
	logic [15:0] attr_len;
	logic        stream_end;
	logic [1:0]  end_status;

	modport source (output valid, is_attr, attr_type, attr_offset, attr_len, stream_end,
		end_status, input ready);
	modport sink   (input valid, is_attr, attr_type, attr_offset, attr_len, stream_end,
		end_status, output ready);
endinterface

// ===== rtl/nlaw_core.sv =====
// ----------------------------------------------------------------------------
// nlaw_core
// Walk state and per-byte update: header assembly, checks, skip count, end.
// ----------------------------------------------------------------------------
module nlaw_core
	import nlaw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         beat_en,
	input  nlaw_beat_t   beat,
	input  logic [13:0]  max_type,
	output logic         res_push,
	output nlaw_result_t res
);

	logic [15:0] total_len_q;
	logic [15:0] byte_cnt_q;
	logic [15:0] remain_q;
	phase_t      phase_q;
	logic [23:0] hdr_q;
	logic [15:0] skip_q;
	logic [15:0] attr_start_q;
	logic [1:0]  stop_q;

	logic [15:0] total_len_d;
	logic [15:0] byte_cnt_d;
	logic [15:0] remain_d;
	phase_t      phase_d;
	logic [23:0] hdr_d;
	logic [15:0] skip_d;
	logic [15:0] attr_start_d;
	logic [1:0]  stop_d;

	always_comb begin
		logic        rep;
		logic        fin;
		logic        start_hdr;
		logic [1:0]  k;
		logic [15:0] len;
		logic [13:0] typ;
		logic [16:0] len_up;
		logic [16:0] padded;
		logic [15:0] roff;
		total_len_d  = total_len_q;
		byte_cnt_d   = byte_cnt_q;
		remain_d     = remain_q;
		phase_d      = phase_q;
		hdr_d        = hdr_q;
		skip_d       = skip_q;
		attr_start_d = attr_start_q;
		stop_d       = stop_q;
		rep          = 1'b0;
		fin          = 1'b0;
		start_hdr    = 1'b0;
		k            = '0;
		len          = hdr_q[15:0];
		typ          = {beat.data_byte[5:0], hdr_q[23:16]};
		len_up       = {1'b0, len} + 17'd3;
		padded       = {len_up[16:2], 2'b00};
		roff         = attr_start_q;

		if (beat_en) begin
			if (beat.first_byte && beat.stream_len == '0) begin
				phase_d = PH_IDLE;
			end else if (beat.first_byte || phase_q != PH_IDLE) begin
				if (beat.first_byte) begin
					total_len_d  = beat.stream_len;
					byte_cnt_d   = '0;
					remain_d     = beat.stream_len;
					attr_start_d = '0;
					phase_d      = PH_HDR;
					hdr_d        = '0;
					skip_d       = '0;
					stop_d       = END_CLEAN;
				end else begin
					byte_cnt_d = byte_cnt_q + 16'd1;
				end
				roff = attr_start_d;

				unique case (phase_d)
					PH_HDR: begin
						k = byte_cnt_d[1:0] - attr_start_d[1:0];
						if (k == 2'd0 && remain_d < HDR_BYTES) begin
							phase_d = PH_DRAIN;
							stop_d  = END_SHORT;
						end else if (k != 2'd3) begin
							case (k)
								2'd0:    hdr_d[7:0]   = beat.data_byte;
								2'd1:    hdr_d[15:8]  = beat.data_byte;
								default: hdr_d[23:16] = beat.data_byte;
							endcase
						end else if (len < HDR_BYTES) begin
							phase_d = PH_DRAIN;
							stop_d  = END_LEN_LOW;
						end else if (len > remain_d) begin
							phase_d = PH_DRAIN;
							stop_d  = END_LEN_OVER;
						end else begin
							// padding past the stream end is cut at the end
							if (padded > {1'b0, remain_d})
								padded = {1'b0, remain_d};
							remain_d = remain_d - padded[15:0];
							skip_d   = padded[15:0] - HDR_BYTES;
							rep      = (typ <= max_type);
							if (skip_d == '0)
								start_hdr = 1'b1;
							else
								phase_d = PH_SKIP;
						end
					end
					PH_SKIP: begin
						if (skip_d != '0)
							skip_d = skip_d - 16'd1;
						if (skip_d == '0)
							start_hdr = 1'b1;
					end
					default: ;
				endcase

				if (start_hdr) begin
					phase_d      = PH_HDR;
					attr_start_d = byte_cnt_d + 16'd1;
					hdr_d        = '0;
				end

				fin = ({1'b0, byte_cnt_d} + 17'd1) >= {1'b0, total_len_d};
				if (fin)
					phase_d = PH_IDLE;
			end
		end

		res_push        = rep || fin;
		res.is_attr     = rep;
		res.attr_type   = rep ? typ : '0;
		res.attr_offset = rep ? roff : '0;
		res.attr_len    = rep ? len : '0;
		res.stream_end  = fin;
		res.end_status  = fin ? stop_d : END_CLEAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_len_q  <= '0;
			byte_cnt_q   <= '0;
			remain_q     <= '0;
			phase_q      <= PH_IDLE;
			hdr_q        <= '0;
			skip_q       <= '0;
			attr_start_q <= '0;
			stop_q       <= END_CLEAN;
		end else begin
			total_len_q  <= total_len_d;
			byte_cnt_q   <= byte_cnt_d;
			remain_q     <= remain_d;
			phase_q      <= phase_d;
			hdr_q        <= hdr_d;
			skip_q       <= skip_d;
			attr_start_q <= attr_start_d;
			stop_q       <= stop_d;
		end
	end

endmodule

// ===== rtl/nlaw_outq.sv =====
// ----------------------------------------------------------------------------
// nlaw_outq
// Two-entry result queue that decouples the walker from the report channel.
// ----------------------------------------------------------------------------
module nlaw_outq
	import nlaw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nlaw_result_t      push_data,
	output logic              can_push,
	nlaw_out_if.source        report
);

	nlaw_result_t entry_q [2];
	logic         rd_ptr_q;
	logic         wr_ptr_q;
	logic [1:0]   cnt_q;
	logic         pop;
	nlaw_result_t head;

	assign pop      = report.valid && report.ready;
	assign can_push = (cnt_q != 2'd2) || report.ready;
	assign head     = entry_q[rd_ptr_q];

	assign report.valid       = (cnt_q != 2'd0);
	assign report.is_attr     = head.is_attr;
	assign report.attr_type   = head.attr_type;
	assign report.attr_offset = head.attr_offset;
	assign report.attr_len    = head.attr_len;
	assign report.stream_end  = head.stream_end;
	assign report.end_status  = head.end_status;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/netlink_attribute_walker.sv =====
// ----------------------------------------------------------------------------
// netlink_attribute_walker
// Walks a netlink attribute stream one byte per beat and reports attributes.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | handshake
//  stream   | in  | data_byte, first_byte, stream_len               | valid/ready
//  report   | out | is_attr, attr_type, attr_offset, attr_len,      | valid/ready
//           |     | stream_end, end_status                          |
//  cfg      | in  | cfg_wr_data (max_type)                          | cfg_wr_en
//
// One byte per cycle while the queue can take results; a beat is registered,
// then updates the walk state and pushes any result into the queue.
// Results sit in a two-entry queue, so input keeps flowing while a report
// is held; stream stalls only when the queue is full and report is not ready.
// Reset clears the walk state and sets max_type to 16383.
// ----------------------------------------------------------------------------
module netlink_attribute_walker
	import nlaw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [13:0] cfg_wr_data,
	nlaw_in_if.sink     stream,
	nlaw_out_if.source  report
);

	logic [13:0]  max_type_q;
	logic         valid_s1;
	nlaw_beat_t   beat_s1;
	logic         can_push;
	logic         advance;
	logic         accept;
	logic         res_push;
	nlaw_result_t res;

	assign advance      = valid_s1 && can_push;
	assign stream.ready = !valid_s1 || can_push;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_type_q <= MAX_TYPE_RESET;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en)
				max_type_q <= cfg_wr_data;
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.data_byte  <= stream.data_byte;
			beat_s1.first_byte <= stream.first_byte;
			beat_s1.stream_len <= stream.stream_len;
		end
	end

	nlaw_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat_en  (advance),
		.beat     (beat_s1),
		.max_type (max_type_q),
		.res_push (res_push),
		.res      (res)
	);

	nlaw_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.can_push  (can_push),
		.report    (report)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the netlink attribute walker. Directed streams hit
// the corner cases of the walk, then random well-formed, broken and noisy
// streams run under three max_type settings and three stall patterns. A
// predictor tracks the walk per accepted beat, and reports are checked in order.
// ----------------------------------------------------------------------------
module tb_top
	import nlaw_pkg::*;
();

	typedef enum int {
		SHAPE_CLEAN,
		SHAPE_TRAILING,
		SHAPE_BAD_LEN,
		SHAPE_NOISE,
		SHAPE_CUT,
		SHAPE_SHORT_PAD
	} stream_shape_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [13:0] cfg_wr_data;

	nlaw_in_if  byte_if ();
	nlaw_out_if rep_if ();

	netlink_attribute_walker u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stream      (byte_if),
		.report      (rep_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// walk state as the block should hold it
	logic [13:0]  w_max;
	logic [15:0]  w_total;
	logic [15:0]  w_count;
	logic [16:0]  w_remain;
	phase_t       w_phase;
	logic [23:0]  w_hdr;
	logic [15:0]  w_skip;
	logic [15:0]  w_start;
	logic [1:0]   w_stop;

	nlaw_result_t expected_reports[$];
	logic [7:0]   stream_buf[$];
	int           walk_beats;
	int           mismatches;
	int           src_idle;
	int           snk_idle;

	function void open_header();
		w_phase = PH_HDR;
		w_start = w_count + 16'd1;
		w_hdr   = '0;
	endfunction

	task automatic walk_predict(input logic [7:0] b, input logic first, input logic [15:0] slen);
		logic [1:0]   k;
		logic [15:0]  len;
		logic [13:0]  typ;
		logic [16:0]  padded;
		logic         rep;
		logic         fin;
		nlaw_result_t r;
		rep = 1'b0;
		fin = 1'b0;
		r   = '0;
		if (first) begin
			if (slen == 16'd0) begin
				w_phase = PH_IDLE;
				return;
			end
			w_total  = slen;
			w_count  = '0;
			w_remain = {1'b0, slen};
			w_start  = '0;
			w_phase  = PH_HDR;
			w_hdr    = '0;
			w_skip   = '0;
			w_stop   = END_CLEAN;
		end else begin
			if (w_phase == PH_IDLE)
				return;
			w_count = w_count + 16'd1;
		end
		walk_beats++;
		case (w_phase)
			PH_HDR: begin
				k = w_count[1:0] - w_start[1:0];
				if (k == 2'd0 && w_remain < 17'd4) begin
					w_phase = PH_DRAIN;
					w_stop  = END_SHORT;
				end else if (k < 2'd3) begin
					w_hdr = w_hdr | ({16'd0, b} << (8 * k));
				end else begin
					len = w_hdr[15:0];
					typ = {b[5:0], w_hdr[23:16]};
					if (len < HDR_BYTES) begin
						w_phase = PH_DRAIN;
						w_stop  = END_LEN_LOW;
					end else if ({1'b0, len} > w_remain) begin
						w_phase = PH_DRAIN;
						w_stop  = END_LEN_OVER;
					end else begin
						// padding that runs past the stream end is cut there
						padded = ({1'b0, len} + 17'd3) & ~17'd3;
						if (padded > w_remain)
							padded = w_remain;
						w_remain = w_remain - padded;
						w_skip   = padded[15:0] - HDR_BYTES;
						if (typ <= w_max) begin
							rep           = 1'b1;
							r.is_attr     = 1'b1;
							r.attr_type   = typ;
							r.attr_offset = w_start;
							r.attr_len    = len;
						end
						if (w_skip == 16'd0)
							open_header();
						else
							w_phase = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (w_skip > 16'd0)
					w_skip = w_skip - 16'd1;
				if (w_skip == 16'd0)
					open_header();
			end
			default: ;
		endcase
		if ({1'b0, w_count} + 17'd1 >= {1'b0, w_total}) begin
			fin          = 1'b1;
			w_phase      = PH_IDLE;
			r.stream_end = 1'b1;
			r.end_status = w_stop;
		end
		if (rep || fin)
			expected_reports.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// one stream beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [7:0] b, input logic first, input logic [15:0] slen);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			byte_if.valid = 1'b0;
			@(negedge clk);
		end
		byte_if.valid      = 1'b1;
		byte_if.data_byte  = b;
		byte_if.first_byte = first;
		byte_if.stream_len = slen;
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		walk_predict(b, first, slen);
	endtask

	// hold the sender until every report is back and the pipeline is empty
	task automatic settle_walk();
		@(negedge clk);
		byte_if.valid = 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_type(input logic [13:0] value);
		settle_walk();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		w_max     = value;
	endtask

	function automatic logic [13:0] pick_type();
		int t;
		case ($urandom_range(3))
			0: t = int'(w_max) + int'($urandom_range(4)) - 2;
			1: t = $urandom_range(16383);
			2: t = 0;
			default: t = 16383;
		endcase
		if (t < 0)
			t = 0;
		if (t > 16383)
			t = 16383;
		return t[13:0];
	endfunction

	task automatic build_attrs(input int count, input bit cut_pad);
		int          len;
		int          pad;
		logic [13:0] typ;
		for (int a = 0; a < count; a++) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(4, 12);
			typ = pick_type();
			stream_buf.push_back(len[7:0]);
			stream_buf.push_back(len[15:8]);
			stream_buf.push_back(typ[7:0]);
			// top two type bits are masked off by the block
			stream_buf.push_back({2'($urandom_range(3)), typ[13:8]});
			repeat (len - 4) stream_buf.push_back(8'($urandom_range(255)));
			pad = (4 - len % 4) % 4;
			if (!(cut_pad && a == count - 1))
				repeat (pad) stream_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_stream(input stream_shape_t shape);
		int slen;
		int tail;
		int len;
		stream_buf.delete();
		case (shape)
			SHAPE_NOISE: begin
				repeat ($urandom_range(1, 12)) stream_buf.push_back(8'($urandom_range(255)));
			end
			SHAPE_BAD_LEN: begin
				build_attrs($urandom_range(0, 2), 1'b0);
				tail = $urandom_range(6);
				len  = $urandom_range(1) ? $urandom_range(3) : 4 + tail + $urandom_range(1, 30);
				stream_buf.push_back(len[7:0]);
				stream_buf.push_back(len[15:8]);
				stream_buf.push_back(8'($urandom_range(255)));
				stream_buf.push_back(8'($urandom_range(255)));
				repeat (tail) stream_buf.push_back(8'($urandom_range(255)));
			end
			default: build_attrs($urandom_range(1, 4), shape == SHAPE_SHORT_PAD);
		endcase
		if (shape == SHAPE_TRAILING)
			repeat ($urandom_range(1, 3)) stream_buf.push_back(8'($urandom_range(255)));
		slen = stream_buf.size();
		// a cut stream claims more bytes than it sends; the next one restarts
		if (shape == SHAPE_CUT)
			slen += $urandom_range(1, 65535 - slen);
		foreach (stream_buf[i])
			send_beat(stream_buf[i], i == 0, (i == 0) ? slen[15:0] : 16'($urandom_range(65535)));
		if (shape != SHAPE_CUT && $urandom_range(5) == 0)
			send_beat(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)));
		if ($urandom_range(9) == 0)
			send_beat(8'($urandom_range(255)), 1'b1, 16'd0);
	endtask

	task automatic run_walk(input int target, input logic [13:0] max_t, input int s_idle,
			input int r_idle);
		int start;
		int streams;
		int r;
		write_max_type(max_t);
		src_idle = s_idle;
		snk_idle = r_idle;
		start    = walk_beats;
		streams  = 0;
		while (walk_beats - start < target) begin
			r = $urandom_range(9);
			send_stream(r < 5 ? SHAPE_CLEAN : stream_shape_t'(r - 4));
			streams++;
			if (streams == 10)
				settle_walk();
		end
		// leave the walk finished so the next register write lands while idle
		send_stream(SHAPE_CLEAN);
	endtask

	task automatic test_special_cases();
		send_beat(8'hFF, 1'b0, 16'hFFFF);   // byte with no stream
		send_beat(8'h00, 1'b1, 16'h0000);   // zero-length stream
		send_beat(8'hA5, 1'b1, 16'd1);      // too short for a header
		send_beat(8'h12, 1'b1, 16'hFFFF);   // abandoned by the next first byte
		send_beat(8'h34, 1'b0, 16'h0000);
		// attribute and stream end on the same beat
		send_beat(8'h04, 1'b1, 16'd4);
		send_beat(8'h00, 1'b0, 16'd0);
		send_beat(8'h01, 1'b0, 16'd0);
		send_beat(8'h00, 1'b0, 16'd0);
		// length below the header size
		send_beat(8'h02, 1'b1, 16'd4);
		send_beat(8'h00, 1'b0, 16'd0);
		send_beat(8'h00, 1'b0, 16'd0);
		send_beat(8'h00, 1'b0, 16'd0);
		// length over the bytes left
		send_beat(8'h08, 1'b1, 16'd4);
		send_beat(8'h00, 1'b0, 16'd0);
		send_beat(8'hFF, 1'b0, 16'd0);
		send_beat(8'h00, 1'b0, 16'd0);
		// widest type, padding runs past the end
		send_beat(8'h05, 1'b1, 16'd7);
		send_beat(8'h00, 1'b0, 16'd0);
		send_beat(8'hFF, 1'b0, 16'd0);
		send_beat(8'hFF, 1'b0, 16'd0);
		send_beat(8'h00, 1'b0, 16'd0);
		send_beat(8'hFF, 1'b0, 16'd0);
		send_beat(8'h00, 1'b0, 16'd0);
	endtask

	task automatic test_walk_mid_types();
		run_walk(340, 14'($urandom_range(1, 16382)), 34, 71);
	endtask

	task automatic test_walk_type_zero();
		run_walk(340, 14'd0, 71, 34);
	endtask

	task automatic test_walk_all_types();
		run_walk(340, MAX_TYPE_RESET, 0, 0);
	endtask

	initial begin
		rep_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rep_if.ready = ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin : check_reports
		nlaw_result_t want;
		if (arst_n && rep_if.valid && rep_if.ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected report", 32'd1, 32'd0);
			end else begin
				want = expected_reports.pop_front();
				if (rep_if.is_attr !== want.is_attr)
					report_mismatch("is_attr", rep_if.is_attr, want.is_attr);
				if (rep_if.attr_type !== want.attr_type)
					report_mismatch("attr_type", rep_if.attr_type, want.attr_type);
				if (rep_if.attr_offset !== want.attr_offset)
					report_mismatch("attr_offset", rep_if.attr_offset, want.attr_offset);
				if (rep_if.attr_len !== want.attr_len)
					report_mismatch("attr_len", rep_if.attr_len, want.attr_len);
				if (rep_if.stream_end !== want.stream_end)
					report_mismatch("stream_end", rep_if.stream_end, want.stream_end);
				if (rep_if.end_status !== want.end_status)
					report_mismatch("end_status", rep_if.end_status, want.end_status);
			end
		end
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		byte_if.valid      = 1'b0;
		byte_if.data_byte  = '0;
		byte_if.first_byte = 1'b0;
		byte_if.stream_len = '0;
		src_idle           = 34;
		snk_idle           = 71;
		mismatches         = 0;
		walk_beats         = 0;
		w_max              = MAX_TYPE_RESET;
		w_total            = '0;
		w_count            = '0;
		w_remain           = '0;
		w_phase            = PH_IDLE;
		w_hdr              = '0;
		w_skip             = '0;
		w_start            = '0;
		w_stop             = END_CLEAN;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_special_cases();
		test_walk_mid_types();
		test_walk_type_zero();
		test_walk_all_types();

		settle_walk();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== netlink_attribute_walker.f =====
rtl/nlaw_pkg.sv
rtl/nlaw_if.sv
rtl/nlaw_core.sv
rtl/nlaw_outq.sv
rtl/netlink_attribute_walker.sv
tb/sv/tb_top.sv
